@@ src/lcc_pkg.sv @@
// lcc_pkg: shared types, field widths and fixed-point constants for the LED color converter
// holds the elaboration-time curve generator used to fill the color temperature ROM
// no dependencies
package lcc_pkg;

    // field widths
    localparam int HUE_W    = 9;
    localparam int PCT_W    = 7;
    localparam int KELVIN_W = 16;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;

    // input ranges
    localparam int HUE_MAX    = 360;
    localparam int PCT_MAX    = 100;
    localparam int KELVIN_LO  = 1000;
    localparam int KELVIN_HI  = 40000;
    localparam int SECTOR_DEG = 60;
    localparam int REM_W      = 6;

    // q16 fixed point
    localparam int FRAC_W  = 16;
    localparam int Q16_W   = 17;
    localparam int ONE_Q16 = 65536;
    localparam int CURVE_W = 24;
    localparam longint MAX_Q16 = 255 * 65536;

    // reciprocal multipliers for division by 100 and by 60
    localparam int PCT_RECIP    = 2684355;
    localparam int PCT_RECIP_SH = 12;
    localparam int HUE_RECIP    = 1118482;
    localparam int HUE_RECIP_SH = 10;

    // black-body curve constants in q16
    localparam longint C_RED     = 21607136;
    localparam longint E_RED     = -8730;
    localparam longint C_GRN_LOG = 6518919;
    localparam longint K_GRN_LOG = 10559132;
    localparam longint C_GRN_POW = 18882375;
    localparam longint E_GRN     = -4949;
    localparam longint C_BLU_LOG = 9077898;
    localparam longint K_BLU_LOG = 19991416;
    localparam longint LN2_Q16   = 45426;
    localparam longint LN2_Q30   = 744261118;

    typedef enum logic
    {
        OP_HSV = 1'b0,
        OP_CCT = 1'b1
    } lcc_op_t;

    typedef enum logic [2:0]
    {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } lcc_sector_t;

    typedef logic [NUM_CH-1:0][CH_W-1:0] lcc_rgb_t;

    // per-stage load enables handed to the temperature datapath
    typedef struct packed
    {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } lcc_adv_t;

    // x/100 in q16, truncated, for x up to 127
    function automatic logic [Q16_W-1:0] pct_q16(input logic [PCT_W-1:0] x);
        logic [PCT_W+21:0] prod;
        prod = (PCT_W+22)'(x) * (PCT_W+22)'(PCT_RECIP);
        return prod[PCT_RECIP_SH +: Q16_W];
    endfunction

    // remainder within a sector (0..59) divided by 60, as a q16 fraction
    function automatic logic [FRAC_W-1:0] hue_frac(input logic [REM_W-1:0] rem);
        logic [26:0] prod;
        prod = 27'(rem) * 27'(HUE_RECIP);
        return prod[HUE_RECIP_SH +: FRAC_W];
    endfunction

    // signed q16 product, truncated toward zero
    function automatic longint smul_q16(input longint a, input longint b);
        return (a * b) / 65536;
    endfunction

    // log2 of a q16 value, bit by bit
    function automatic longint log2_q16(input longint x);
        longint t;
        longint m;
        longint fr;
        int n;
        if (x == 0)
            return -longint'(32) * 65536;
        n = 0;
        t = x;
        while (t > 1)
        begin
            t = t >> 1;
            n++;
        end
        m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
        fr = 0;
        for (int bt = 15; bt >= 0; bt--)
        begin
            m = (m * m) >> 30;
            if (m >= (longint'(2) << 30))
            begin
                m = m >> 1;
                fr = fr | (longint'(1) << bt);
            end
        end
        return longint'(n - 16) * 65536 + fr;
    endfunction

    function automatic longint ln_q16(input longint x);
        return smul_q16(log2_q16(x), LN2_Q16);
    endfunction

    // quotient of a nonnegative value by a small divisor, shift and subtract
    function automatic longint div_small(input longint num, input int den);
        longint rem;
        longint quo;
        rem = 0;
        quo = 0;
        for (int bt = 62; bt >= 0; bt--)
        begin
            rem = (rem << 1) | ((num >> bt) & longint'(1));
            quo = quo << 1;
            if (rem >= longint'(den))
            begin
                rem = rem - longint'(den);
                quo = quo | longint'(1);
            end
        end
        return quo;
    endfunction

    // 2^y for q16 y, fraction part by a q30 series
    function automatic longint exp2_q16(input longint y);
        longint n;
        longint f;
        longint tt;
        longint term;
        longint sum;
        int sh;
        if (y >= 0)
            n = y / 65536;
        else
            n = -((-y + 65535) / 65536);
        f = y - n * 65536;
        tt = (f * LN2_Q30) >> 16;
        term = longint'(1) << 30;
        sum = term;
        for (int k = 1; k <= 12; k++)
        begin
            term = div_small((term * tt) >> 30, k);
            sum = sum + term;
        end
        if (n > 30)
            n = 30;
        sh = int'(n) - 14;
        if (sh >= 0)
            return sum << sh;
        if (-sh >= 63)
            return 0;
        return sum >> (-sh);
    endfunction

    function automatic longint pow_q16(input longint x, input longint e);
        return exp2_q16(smul_q16(log2_q16(x), e));
    endfunction

    function automatic logic [CURVE_W-1:0] clamp_q16(input longint v);
        if (v < 0)
            return '0;
        if (v > MAX_Q16)
            return CURVE_W'(MAX_Q16);
        return CURVE_W'(v);
    endfunction

    // curve sample at a given temperature, packed blue, green, red (red lowest)
    function automatic logic [NUM_CH*CURVE_W-1:0] curve_word(input longint kelv);
        longint tq;
        logic [CURVE_W-1:0] r;
        logic [CURVE_W-1:0] g;
        logic [CURVE_W-1:0] b;
        tq = (kelv * ONE_Q16) / 100;
        if (tq <= 60 * ONE_Q16)
            r = CURVE_W'(MAX_Q16);
        else
            r = clamp_q16(smul_q16(C_RED, pow_q16(tq - 60 * ONE_Q16, E_RED)));
        if (tq <= 66 * ONE_Q16)
            g = clamp_q16(smul_q16(C_GRN_LOG, ln_q16(tq)) - K_GRN_LOG);
        else
            g = clamp_q16(smul_q16(C_GRN_POW, pow_q16(tq - 60 * ONE_Q16, E_GRN)));
        if (tq >= 66 * ONE_Q16)
            b = CURVE_W'(MAX_Q16);
        else if (tq <= 19 * ONE_Q16)
            b = '0;
        else
            b = clamp_q16(smul_q16(C_BLU_LOG, ln_q16(tq - 10 * ONE_Q16)) - K_BLU_LOG);
        return {b, g, r};
    endfunction

endpackage

@@ src/lcc_if.sv @@
// lcc_if: valid/ready channel interfaces for the converter's settings and color words
// depends on lcc_pkg for field widths
interface lcc_settings_if;
    import lcc_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [HUE_W-1:0]    hue;
    logic [PCT_W-1:0]    saturation;
    logic [PCT_W-1:0]    value;
    logic [PCT_W-1:0]    brightness;
    logic [KELVIN_W-1:0] kelvin;
    logic                power;

    modport source
    (
        output valid, op, hue, saturation, value, brightness, kelvin, power,
        input  ready
    );

    modport sink
    (
        input  valid, op, hue, saturation, value, brightness, kelvin, power,
        output ready
    );
endinterface

interface lcc_color_if;
    import lcc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source
    (
        output valid, red, green, blue,
        input  ready
    );

    modport sink
    (
        input  valid, red, green, blue,
        output ready
    );
endinterface

@@ src/lcc_cct.sv @@
// lcc_cct: color temperature datapath, kelvin to per-channel level over five stages
// curve ROM filled at elaboration, two-port registered read, linear interpolation
// depends on lcc_pkg
module lcc_cct #(
    parameter int KELVIN_STEP = 100
) (
    input  logic                         clk,
    input  lcc_pkg::lcc_adv_t            adv,
    input  logic [lcc_pkg::KELVIN_W-1:0] kelvin,
    output lcc_pkg::lcc_rgb_t            ch
);
    import lcc_pkg::*;

    localparam int TblN   = KELVIN_HI / KELVIN_STEP + 2;
    localparam int IdxW   = $clog2(TblN);
    localparam int WtW    = $clog2(KELVIN_STEP + 1);
    localparam int SumW   = CURVE_W + WtW + 1;
    localparam int HiW    = SumW - FRAC_W;
    localparam int RecipW = 32;
    localparam int KMulW  = KELVIN_W + RecipW;
    localparam int HMulW  = HiW + RecipW;
    // ceiling reciprocal of the step, exact for every dividend used here
    localparam logic [RecipW-1:0] Recip =
        RecipW'(((64'd1 << RecipW) + 64'(KELVIN_STEP) - 64'd1) / 64'(KELVIN_STEP));
    localparam logic [WtW-1:0] StepW = WtW'(KELVIN_STEP);

    typedef logic [NUM_CH*CURVE_W-1:0] rom_word_t;
    typedef rom_word_t rom_arr_t [TblN];
    typedef logic [NUM_CH-1:0][SumW-1:0] sum_arr_t;

    function automatic rom_arr_t build_rom();
        rom_arr_t rom;
        for (int i = 0; i < TblN; i++)
        begin
            rom[i] = curve_word(longint'(i) * KELVIN_STEP);
        end
        return rom;
    endfunction

    localparam rom_arr_t CurveRom = build_rom();

    logic [KELVIN_W-1:0] kel_next;
    logic [KMulW-1:0]    kprod;
    logic [IdxW-1:0]     idx_next;
    logic [KELVIN_W-1:0] kel1_reg;
    logic [IdxW-1:0]     idx1_reg;
    logic [KELVIN_W-1:0] base2;
    logic [WtW-1:0]      fr_next;
    logic [IdxW-1:0]     idx2_reg;
    logic [WtW-1:0]      fr2_reg;
    rom_word_t           e0_reg;
    rom_word_t           e1_reg;
    logic [WtW-1:0]      fr3_reg;
    sum_arr_t            sum_next;
    sum_arr_t            sum4_reg;
    lcc_rgb_t            ch_next;
    lcc_rgb_t            ch_reg;

    // stage 1: clamp kelvin and form the table index
    always_comb
    begin
        if (kelvin < KELVIN_W'(KELVIN_LO))
            kel_next = KELVIN_W'(KELVIN_LO);
        else if (kelvin > KELVIN_W'(KELVIN_HI))
            kel_next = KELVIN_W'(KELVIN_HI);
        else
            kel_next = kelvin;
        kprod    = KMulW'(kel_next) * KMulW'(Recip);
        idx_next = kprod[RecipW +: IdxW];
    end

    // stage 2: position between table entries
    assign base2   = KELVIN_W'(idx1_reg) * KELVIN_W'(KELVIN_STEP);
    assign fr_next = WtW'(kel1_reg - base2);

    // stage 4: weighted sum of the two neighboring entries
    always_comb
    begin
        for (int j = 0; j < NUM_CH; j++)
        begin
            sum_next[j] = SumW'(e0_reg[j*CURVE_W +: CURVE_W]) * SumW'(StepW - fr3_reg)
                        + SumW'(e1_reg[j*CURVE_W +: CURVE_W]) * SumW'(fr3_reg);
        end
    end

    // stage 5: divide by step and drop the q16 fraction
    always_comb
    begin
        logic [HMulW-1:0] hprod;
        for (int j = 0; j < NUM_CH; j++)
        begin
            hprod      = HMulW'(sum4_reg[j][FRAC_W +: HiW]) * HMulW'(Recip);
            ch_next[j] = hprod[RecipW +: CH_W];
        end
    end

    // stage registers, the rom read is the stage 3 register
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            kel1_reg <= kel_next;
            idx1_reg <= idx_next;
        end
        if (adv.s2)
        begin
            idx2_reg <= idx1_reg;
            fr2_reg  <= fr_next;
        end
        if (adv.s3)
        begin
            e0_reg  <= CurveRom[idx2_reg];
            e1_reg  <= CurveRom[idx2_reg + IdxW'(1)];
            fr3_reg <= fr2_reg;
        end
        if (adv.s4)
        begin
            sum4_reg <= sum_next;
        end
        if (adv.s5)
        begin
            ch_reg <= ch_next;
        end
    end

    assign ch = ch_reg;

endmodule

@@ src/led_color_converter_core.sv @@
// led_color_converter_core: settings word in, one 8-bit rgb word out, six register stages
// path: a settings word is registered in stage 1 and passes stages 2 to 6 in turn; color.valid is the stage 6 valid bit
// throughput: one word per cycle; each stage stalls only while the one after it is full
// reset: rst_n clears the stage valid bits; the curve ROM is a constant and needs no fill
// depends on lcc_pkg, lcc_if (lcc_settings_if, lcc_color_if) and lcc_cct
module led_color_converter_core #(
    parameter int KELVIN_STEP = 100
) (
    input logic        clk,
    input logic        rst_n,
    lcc_settings_if.sink settings,
    lcc_color_if.source  color
);
    import lcc_pkg::*;

    localparam int MulW  = 2 * Q16_W;
    localparam int ChMulW = CH_W + Q16_W;

    // stage control
    logic [6:1] vld_reg;
    logic [6:1] vld_next;
    logic [6:1] rdy;
    lcc_adv_t   adv;

    // stage 1
    logic [HUE_W-1:0] hue_sat;
    logic [HUE_W-1:0] base;
    lcc_sector_t      sec_next;
    logic [REM_W-1:0] rem_next;
    logic [PCT_W-1:0] sat_next;
    logic [PCT_W-1:0] val_next;
    logic [PCT_W-1:0] bri_next;
    lcc_op_t          op1_reg;
    logic             pwr1_reg;
    lcc_sector_t      sec1_reg;
    logic [REM_W-1:0] rem1_reg;
    logic [PCT_W-1:0] sat1_reg;
    logic [PCT_W-1:0] val1_reg;
    logic [PCT_W-1:0] bri1_reg;

    // stage 2
    lcc_op_t           op2_reg;
    logic              pwr2_reg;
    lcc_sector_t       sec2_reg;
    logic [FRAC_W-1:0] f2_reg;
    logic [Q16_W-1:0]  sf2_reg;
    logic [Q16_W-1:0]  vf2_reg;
    logic [Q16_W-1:0]  bf2_reg;

    // stage 3
    logic [MulW-1:0]   fs_prod;
    logic [MulW-1:0]   gs_prod;
    logic [MulW-1:0]   p_prod;
    lcc_op_t           op3_reg;
    logic              pwr3_reg;
    lcc_sector_t       sec3_reg;
    logic [FRAC_W-1:0] fs3_reg;
    logic [Q16_W-1:0]  gs3_reg;
    logic [Q16_W-1:0]  p3_reg;
    logic [Q16_W-1:0]  vf3_reg;
    logic [Q16_W-1:0]  bf3_reg;

    // stage 4
    logic [MulW-1:0]  q_prod;
    logic [MulW-1:0]  t_prod;
    lcc_op_t          op4_reg;
    logic             pwr4_reg;
    lcc_sector_t      sec4_reg;
    logic [Q16_W-1:0] q4_reg;
    logic [Q16_W-1:0] t4_reg;
    logic [Q16_W-1:0] p4_reg;
    logic [Q16_W-1:0] vf4_reg;
    logic [Q16_W-1:0] bf4_reg;

    // stage 5
    lcc_rgb_t         hsv_ch_next;
    lcc_op_t          op5_reg;
    logic             pwr5_reg;
    lcc_rgb_t         hsv_ch5_reg;
    logic [Q16_W-1:0] bf5_reg;
    lcc_rgb_t         cct_ch;

    // stage 6, output register
    lcc_rgb_t out_next;
    lcc_rgb_t out_rgb_reg;

    // ready ripples back from the output, so bubbles are filled
    always_comb
    begin
        rdy[6] = !vld_reg[6] || color.ready;
        for (int k = 5; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_next       = {vld_reg[5:1], settings.valid};
    assign settings.ready = rdy[1];
    assign adv            = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= (rdy & vld_next) | (~rdy & vld_reg);
    end

    // stage 1: clamp inputs, split hue into sector and remainder
    always_comb
    begin
        hue_sat  = (settings.hue > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : settings.hue;
        sat_next = (settings.saturation > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                           : settings.saturation;
        val_next = (settings.value > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : settings.value;
        bri_next = (settings.brightness > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                           : settings.brightness;
        sec_next = SEC_R_Y;
        base     = '0;
        // full circle wraps back to the first sector
        priority if (hue_sat >= HUE_W'(HUE_MAX))
        begin
            sec_next = SEC_R_Y;
            base     = HUE_W'(HUE_MAX);
        end
        else if (hue_sat >= HUE_W'(5 * SECTOR_DEG))
        begin
            sec_next = SEC_M_R;
            base     = HUE_W'(5 * SECTOR_DEG);
        end
        else if (hue_sat >= HUE_W'(4 * SECTOR_DEG))
        begin
            sec_next = SEC_B_M;
            base     = HUE_W'(4 * SECTOR_DEG);
        end
        else if (hue_sat >= HUE_W'(3 * SECTOR_DEG))
        begin
            sec_next = SEC_C_B;
            base     = HUE_W'(3 * SECTOR_DEG);
        end
        else if (hue_sat >= HUE_W'(2 * SECTOR_DEG))
        begin
            sec_next = SEC_G_C;
            base     = HUE_W'(2 * SECTOR_DEG);
        end
        else if (hue_sat >= HUE_W'(SECTOR_DEG))
        begin
            sec_next = SEC_Y_G;
            base     = HUE_W'(SECTOR_DEG);
        end
        else
        begin
            sec_next = SEC_R_Y;
            base     = '0;
        end
        rem_next = REM_W'(hue_sat - base);
    end

    // stage 3: first level of hsv products
    assign fs_prod = MulW'(f2_reg) * MulW'(sf2_reg);
    assign gs_prod = MulW'(Q16_W'(ONE_Q16) - Q16_W'(f2_reg)) * MulW'(sf2_reg);
    assign p_prod  = MulW'(vf2_reg) * MulW'(Q16_W'(ONE_Q16) - sf2_reg);

    // stage 4: second level of hsv products
    assign q_prod = MulW'(vf3_reg) * MulW'(Q16_W'(ONE_Q16) - Q16_W'(fs3_reg));
    assign t_prod = MulW'(vf3_reg) * MulW'(Q16_W'(ONE_Q16) - gs3_reg);

    // stage 5: pick channels by sector and scale to 0..255
    always_comb
    begin
        logic [NUM_CH-1:0][Q16_W-1:0] c;
        logic [Q16_W+CH_W-1:0]        c255;
        unique case (sec4_reg)
            SEC_R_Y: c = {p4_reg, t4_reg, vf4_reg};
            SEC_Y_G: c = {p4_reg, vf4_reg, q4_reg};
            SEC_G_C: c = {t4_reg, vf4_reg, p4_reg};
            SEC_C_B: c = {vf4_reg, q4_reg, p4_reg};
            SEC_B_M: c = {vf4_reg, p4_reg, t4_reg};
            default: c = {q4_reg, p4_reg, vf4_reg};
        endcase
        for (int j = 0; j < NUM_CH; j++)
        begin
            c255           = ((Q16_W+CH_W)'(c[j]) << CH_W) - (Q16_W+CH_W)'(c[j]);
            hsv_ch_next[j] = c255[FRAC_W +: CH_W];
        end
    end

    // stage 6: brightness scale, power gate in hue mode
    always_comb
    begin
        logic [CH_W-1:0]   sel;
        logic [ChMulW-1:0] scaled;
        for (int j = 0; j < NUM_CH; j++)
        begin
            sel    = (op5_reg == OP_CCT) ? cct_ch[j] : hsv_ch5_reg[j];
            scaled = ChMulW'(sel) * ChMulW'(bf5_reg);
            if (op5_reg == OP_HSV && !pwr5_reg)
                out_next[j] = '0;
            else if (scaled[FRAC_W +: CH_W+1] > (CH_W+1)'(255))
                out_next[j] = '1;
            else
                out_next[j] = scaled[FRAC_W +: CH_W];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            op1_reg  <= lcc_op_t'(settings.op);
            pwr1_reg <= settings.power;
            sec1_reg <= sec_next;
            rem1_reg <= rem_next;
            sat1_reg <= sat_next;
            val1_reg <= val_next;
            bri1_reg <= bri_next;
        end
        if (rdy[2])
        begin
            op2_reg  <= op1_reg;
            pwr2_reg <= pwr1_reg;
            sec2_reg <= sec1_reg;
            f2_reg   <= hue_frac(rem1_reg);
            sf2_reg  <= pct_q16(sat1_reg);
            vf2_reg  <= pct_q16(val1_reg);
            bf2_reg  <= pct_q16(bri1_reg);
        end
        if (rdy[3])
        begin
            op3_reg  <= op2_reg;
            pwr3_reg <= pwr2_reg;
            sec3_reg <= sec2_reg;
            fs3_reg  <= fs_prod[FRAC_W +: FRAC_W];
            gs3_reg  <= gs_prod[FRAC_W +: Q16_W];
            p3_reg   <= p_prod[FRAC_W +: Q16_W];
            vf3_reg  <= vf2_reg;
            bf3_reg  <= bf2_reg;
        end
        if (rdy[4])
        begin
            op4_reg  <= op3_reg;
            pwr4_reg <= pwr3_reg;
            sec4_reg <= sec3_reg;
            q4_reg   <= q_prod[FRAC_W +: Q16_W];
            t4_reg   <= t_prod[FRAC_W +: Q16_W];
            p4_reg   <= p3_reg;
            vf4_reg  <= vf3_reg;
            bf4_reg  <= bf3_reg;
        end
        if (rdy[5])
        begin
            op5_reg     <= op4_reg;
            pwr5_reg    <= pwr4_reg;
            hsv_ch5_reg <= hsv_ch_next;
            bf5_reg     <= bf4_reg;
        end
        if (rdy[6])
        begin
            out_rgb_reg <= out_next;
        end
    end

    // color temperature datapath, aligned with stages 1 to 5
    lcc_cct #(
        .KELVIN_STEP (KELVIN_STEP)
    ) u_cct (
        .clk    (clk),
        .adv    (adv),
        .kelvin (settings.kelvin),
        .ch     (cct_ch)
    );

    assign color.valid = vld_reg[6];
    assign color.red   = out_rgb_reg[0];
    assign color.green = out_rgb_reg[1];
    assign color.blue  = out_rgb_reg[2];

`ifndef SYNTHESIS
    // input is refused only when every stage holds a word
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rdy[1] |-> (&vld_reg))
        else $error("input stalled with an empty stage");

    // a stalled stage 5 word stays in place
    a_stage5_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] && !rdy[5] |=> vld_reg[5])
        else $error("stage 5 word lost during stall");

    // sector split leaves a remainder below one sector
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> rem1_reg < REM_W'(SECTOR_DEG))
        else $error("hue remainder out of sector");

    // percent conversions never exceed one
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> sf2_reg <= Q16_W'(ONE_Q16) && vf2_reg <= Q16_W'(ONE_Q16)
                       && bf2_reg <= Q16_W'(ONE_Q16))
        else $error("percent fraction above one");

    // q and t never exceed value
    a_qt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> q4_reg <= vf4_reg && t4_reg <= vf4_reg)
        else $error("hsv intermediate above value");
`endif

endmodule
